// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// assertion with reset guard
`define BAE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion checked in reset as well
`define BAE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BAE_ASSERT(label, clk, rst, prop, msg)
`define BAE_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ----- rtl/bae_pkg.sv -----
// ----------------------------------------------------------------------------
// bae_pkg
// Shared widths and defaults for the binary arithmetic encoder.
// ----------------------------------------------------------------------------
package bae_pkg;

  localparam int PROB_BITS_DEF  = 15;  // probability precision
  localparam int WORD_W         = 64;  // low / range word
  localparam int MUL_A_W        = 32;  // multiplier slice of the range
  localparam int PROB_W         = 15;
  localparam int BYTE_W         = 8;
  localparam int CARRY_W        = 2;

endpackage

// ----- rtl/bae_mul.sv -----
// ----------------------------------------------------------------------------
// bae_mul
// Shared 32 x (PROB_BITS+1) multiplier with registered product.
// ----------------------------------------------------------------------------
module bae_mul #(
  parameter int B_W = bae_pkg::PROB_BITS_DEF + 1
) (
  input  logic                          clk,
  input  logic [bae_pkg::MUL_A_W-1:0]   a,
  input  logic [B_W-1:0]                b,
  output logic [bae_pkg::MUL_A_W+B_W-1:0] prod
);

  localparam int P_W = bae_pkg::MUL_A_W + B_W;

  always_ff @(posedge clk) begin
    prod <= P_W'(a) * P_W'(b);
  end

endmodule

// ----- rtl/binary_arithmetic_encoder_core.sv -----
// A coded decision holds the input stalled through the multiply, accumulate, adjust
// and low-update states, then through renormalisation (its first word loads in the
// renormalisation state after the low update); a flush adds the span, hi and check
// states before its words. One uncoded decision per cycle without a flush; coded ones
// wait on the shared 32-bit slice multiplier's two passes, then serial byte output.
// Reset (rst, synchronous): coder state back to low 0, full range, no pending word.
// ----------------------------------------------------------------------------
// binary_arithmetic_encoder_core
// 64-bit binary range coder: multiplies the interval down per decision,
// emits three bytes on renormalisation, signals carries and flushes on request.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module binary_arithmetic_encoder_core #(
  parameter int PROB_BITS = bae_pkg::PROB_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // input words
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        bit_value,
  input  logic [bae_pkg::PROB_W-1:0]  prob_one,
  input  logic                        end_of_block,
  // output words
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bae_pkg::BYTE_W-1:0]  out_byte,
  output logic                        byte_present,
  output logic [bae_pkg::CARRY_W-1:0] carry_count,
  output logic                        last_of_run,
  output logic                        stream_done
);

  localparam int W      = bae_pkg::WORD_W;
  localparam int AW     = bae_pkg::MUL_A_W;
  localparam int BW     = PROB_BITS + 1;
  localparam int PW     = AW + BW;
  localparam int CW     = bae_pkg::CARRY_W;
  localparam int BYW    = bae_pkg::BYTE_W;

  localparam logic [W-1:0]  RangeReset  = W'(1) << (W - PROB_BITS);
  localparam logic [W-1:0]  RenormLimit = W'(1) << (33 - PROB_BITS);
  localparam logic [BW-1:0] ProbScale   = BW'(1) << PROB_BITS;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ACC,
    ST_ADJ,
    ST_LOW,
    ST_RENORM,
    ST_FLUSH_SPAN,
    ST_FLUSH_HI,
    ST_FLUSH_CHK,
    ST_FLUSH_EMIT,
    ST_FLUSH_WRAP
  } state_t;

  state_t state;

  logic [W-1:0]  interval_low;
  logic [W-1:0]  interval_range;
  logic [W-1:0]  low_at_renorm;
  logic [W-1:0]  scaled;
  logic [W-1:0]  delta;
  logic [W-1:0]  span;
  logic [W-1:0]  hi;
  logic [W-1:0]  diff;
  logic          coded_bit;
  logic [BW-1:0] sub_width;
  logic          flush_req;
  logic          renorm_due;
  logic          pending;
  logic [1:0]    byte_idx;

  logic [AW-1:0]          mul_a;
  logic [PW-1:0]          prod;
  logic [PROB_BITS-1:0]   prob_sat;
  logic [BW-1:0]          width_in;
  logic                   slot_free;
  logic                   word_load;
  logic [BYW-1:0]         renorm_byte;
  logic [W-1:0]           range_next;

  // probability saturation and subinterval width of the incoming decision
  always_comb begin
    if ({1'b0, prob_one} >= (bae_pkg::PROB_W + 1)'(ProbScale)) begin
      prob_sat = '1;
    end else begin
      prob_sat = prob_one[PROB_BITS-1:0];
    end
    width_in = bit_value ? {1'b0, prob_sat} : ProbScale - {1'b0, prob_sat};
  end

  assign mul_a      = (state == ST_MUL_HI) ? interval_range[W-1:AW] : interval_range[AW-1:0];
  assign slot_free  = !out_valid || !out_stall;
  assign word_load  = slot_free && ((state == ST_RENORM) || (state == ST_FLUSH_EMIT) ||
                                    (state == ST_FLUSH_WRAP));
  assign in_stall   = (state != ST_IDLE);
  assign range_next = scaled >> PROB_BITS;

  always_comb begin
    case (byte_idx)
      2'd0:    renorm_byte = interval_low[63:56];
      2'd1:    renorm_byte = interval_low[55:48];
      default: renorm_byte = interval_low[47:40];
    endcase
  end

  bae_mul #(
    .B_W (BW)
  ) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (sub_width),
    .prod (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      interval_low   <= '0;
      interval_range <= RangeReset;
      low_at_renorm  <= '0;
    end else begin
      if (word_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            coded_bit <= bit_value;
            sub_width <= width_in;
            flush_req <= end_of_block;
            if (prob_one != '0) begin
              state <= ST_MUL_LO;
            end else if (end_of_block) begin
              state <= ST_FLUSH_SPAN;
            end
          end
        end
        ST_MUL_LO: begin
          state <= ST_MUL_HI;
        end
        ST_MUL_HI: begin
          scaled <= W'(prod);
          state  <= ST_ACC;
        end
        ST_ACC: begin
          // upper slice product lands at bit 32, wrapping mod 2^64
          scaled <= scaled + {prod[AW-1:0], {AW{1'b0}}};
          state  <= ST_ADJ;
        end
        ST_ADJ: begin
          // a one keeps the upper part: low moves by range*scale - range*width
          delta          <= coded_bit ? (interval_range << PROB_BITS) - scaled : '0;
          interval_range <= range_next;
          renorm_due     <= (range_next <= RenormLimit);
          state          <= ST_LOW;
        end
        ST_LOW: begin
          interval_low <= interval_low + delta;
          byte_idx     <= 2'd0;
          if (renorm_due) begin
            state <= ST_RENORM;
          end else if (flush_req) begin
            state <= ST_FLUSH_SPAN;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_RENORM: begin
          if (slot_free) begin
            out_byte     <= renorm_byte;
            byte_present <= 1'b1;
            carry_count  <= ((byte_idx == 2'd0) && (interval_low < low_at_renorm)) ?
                            CW'(1) : CW'(0);
            last_of_run  <= (byte_idx == 2'd2) && !flush_req;
            stream_done  <= 1'b0;
            byte_idx     <= byte_idx + 2'd1;
            if (byte_idx == 2'd2) begin
              interval_low   <= interval_low << 24;
              low_at_renorm  <= interval_low << 24;
              interval_range <= scaled << (24 - PROB_BITS);
              state          <= flush_req ? ST_FLUSH_SPAN : ST_IDLE;
            end
          end
        end
        ST_FLUSH_SPAN: begin
          span    <= (interval_range << PROB_BITS) - W'(1);
          pending <= (interval_low < low_at_renorm);
          state   <= ST_FLUSH_HI;
        end
        ST_FLUSH_HI: begin
          hi    <= interval_low + span;
          state <= ST_FLUSH_CHK;
        end
        ST_FLUSH_CHK: begin
          diff  <= interval_low ^ hi;
          state <= (hi > interval_low) ? ST_FLUSH_EMIT : ST_FLUSH_WRAP;
        end
        ST_FLUSH_EMIT: begin
          if (slot_free) begin
            out_byte     <= hi[63:56];
            byte_present <= 1'b1;
            carry_count  <= CW'(pending);
            pending      <= 1'b0;
            if (diff[63:56] == '0) begin
              // top bytes of low and hi still agree
              hi          <= hi << 8;
              diff        <= diff << 8;
              last_of_run <= 1'b0;
              stream_done <= 1'b0;
            end else begin
              last_of_run    <= 1'b1;
              stream_done    <= 1'b1;
              interval_low   <= '0;
              interval_range <= RangeReset;
              low_at_renorm  <= '0;
              state          <= ST_IDLE;
            end
          end
        end
        ST_FLUSH_WRAP: begin
          // hi wrapped: carry-only word
          if (slot_free) begin
            out_byte       <= '0;
            byte_present   <= 1'b0;
            carry_count    <= CW'(pending) + CW'(1);
            last_of_run    <= 1'b1;
            stream_done    <= 1'b1;
            interval_low   <= '0;
            interval_range <= RangeReset;
            low_at_renorm  <= '0;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `BAE_ASSERT(a_done_is_last, clk, rst, out_valid && stream_done |-> last_of_run,
              "stream_done without last_of_run")
  `BAE_ASSERT(a_carry_range, clk, rst, out_valid |-> carry_count != 2'd3,
              "carry_count out of range")
  `BAE_ASSERT(a_carry_only, clk, rst,
              out_valid && !byte_present |-> stream_done && carry_count != 2'd0,
              "bad carry-only word")
  `BAE_ASSERT(a_flush_reset, clk, rst,
              state == ST_IDLE && $past(state) == ST_FLUSH_EMIT |->
              interval_low == '0 && interval_range == RangeReset,
              "coder not reset after flush")

endmodule

// ----- dv/bae_checker.sv -----
// ----------------------------------------------------------------------------
// bae_checker
// Watches both channels of the binary arithmetic encoder, predicts the code
// words that each accepted decision should produce and compares them in order.
// ----------------------------------------------------------------------------
module bae_checker #(
  parameter int PROB_BITS = bae_pkg::PROB_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        bit_value,
  input  logic [bae_pkg::PROB_W-1:0]  prob_one,
  input  logic                        end_of_block,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [bae_pkg::BYTE_W-1:0]  out_byte,
  input  logic                        byte_present,
  input  logic [bae_pkg::CARRY_W-1:0] carry_count,
  input  logic                        last_of_run,
  input  logic                        stream_done,
  output int                          fail_count,
  output int                          words_owed
);

  localparam logic [63:0] PROB_SCALE   = 64'd1 << PROB_BITS;
  localparam logic [63:0] RENORM_LIMIT = 64'd1 << (33 - PROB_BITS);
  localparam logic [63:0] FULL_RANGE   = 64'd1 << (64 - PROB_BITS);

  typedef struct packed {
    logic [bae_pkg::BYTE_W-1:0]  code_byte;
    logic                        present;
    logic [bae_pkg::CARRY_W-1:0] carry;
    logic                        last;
    logic                        done;
  } code_word_t;

  code_word_t  owed_words[$];
  logic [63:0] coder_low;
  logic [63:0] coder_range;
  logic [63:0] renorm_low;
  int          mismatches = 0;

  assign fail_count = mismatches;

  function automatic void coder_reset();
    coder_low   = 64'd0;
    coder_range = FULL_RANGE;
    renorm_low  = 64'd0;
  endfunction

  function automatic void push_word(logic [7:0] b, logic present, logic [1:0] carry);
    code_word_t w;
    w.code_byte = b;
    w.present   = present;
    w.carry     = carry;
    w.last      = 1'b0;
    w.done      = 1'b0;
    owed_words.push_back(w);
  endfunction

  // narrows the interval for one decision, queues renormalisation and flush words
  function automatic void code_decision(logic b, logic [bae_pkg::PROB_W-1:0] prob,
                                        logic eob);
    logic [63:0] p;
    logic [63:0] base;
    logic [63:0] width;
    logic [63:0] scaled;
    logic [63:0] hi;
    logic [63:0] diff;
    logic [1:0]  pend;
    int          first;
    first = owed_words.size();
    p = 64'(prob);
    if (p != 64'd0) begin
      if (p >= PROB_SCALE) p = PROB_SCALE - 64'd1;
      base   = b ? (PROB_SCALE - p) : 64'd0;
      width  = b ? p : (PROB_SCALE - p);
      coder_low   = coder_low + coder_range * base;
      scaled      = coder_range * width;
      coder_range = scaled >> PROB_BITS;
      if (coder_range <= RENORM_LIMIT) begin
        // low below the last renorm value means it wrapped: one carry
        push_word(coder_low[63:56], 1'b1, (coder_low < renorm_low) ? 2'd1 : 2'd0);
        push_word(coder_low[55:48], 1'b1, 2'd0);
        push_word(coder_low[47:40], 1'b1, 2'd0);
        coder_low   = coder_low << 24;
        coder_range = scaled << (24 - PROB_BITS);
        renorm_low  = coder_low;
      end
    end
    if (eob) begin
      pend = (coder_low < renorm_low) ? 2'd1 : 2'd0;
      hi   = coder_low + ((coder_range << PROB_BITS) - 64'd1);
      if (hi > coder_low) begin
        diff = coder_low ^ hi;
        while (diff[63:56] == 8'd0) begin
          push_word(hi[63:56], 1'b1, pend);
          pend = 2'd0;
          hi   = hi << 8;
          diff = diff << 8;
        end
        push_word(hi[63:56], 1'b1, pend);
      end else begin
        // hi wrapped: carry-only word
        push_word(8'd0, 1'b0, pend + 2'd1);
      end
      owed_words[owed_words.size()-1].done = 1'b1;
      coder_reset();
    end
    if (owed_words.size() > first) owed_words[owed_words.size()-1].last = 1'b1;
  endfunction

  // fields shown as byte/present/carry/last/done
  function automatic void report(string what, code_word_t want, code_word_t got);
    mismatches = mismatches + 1;
    if (mismatches <= 10)
      $display("%0t %s: expected %02h/%0d/%0d/%0d/%0d, got %02h/%0d/%0d/%0d/%0d",
               $realtime, what, want.code_byte, want.present, want.carry, want.last,
               want.done, got.code_byte, got.present, got.carry, got.last, got.done);
  endfunction

  initial coder_reset();

  always @(posedge clk) begin
    code_word_t got;
    code_word_t want;
    if (rst) begin
      coder_reset();
      owed_words.delete();
    end else begin
      if (in_valid && !in_stall) code_decision(bit_value, prob_one, end_of_block);
      if (out_valid && !out_stall) begin
        got.code_byte = out_byte;
        got.present   = byte_present;
        got.carry     = carry_count;
        got.last      = last_of_run;
        got.done      = stream_done;
        if (owed_words.size() == 0) begin
          want = '0;
          report("unexpected word", want, got);
        end else begin
          want = owed_words.pop_front();
          if (want != got) report("word mismatch", want, got);
        end
      end
    end
    words_owed <= owed_words.size();
  end

endmodule

// ----- dv/tb_binary_arithmetic_encoder_core.sv -----
// ----------------------------------------------------------------------------
// tb_binary_arithmetic_encoder_core
// Drives directed and random decision streams with flushes into the encoder, with
// random stalls on both sides and a long receiver hold-off; the checker scores the output.
// ----------------------------------------------------------------------------
module tb_binary_arithmetic_encoder_core;

  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 137;

  logic                        clk;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        bit_value = 1'b0;
  logic [bae_pkg::PROB_W-1:0]  prob_one = '0;
  logic                        end_of_block = 1'b0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [bae_pkg::BYTE_W-1:0]  out_byte;
  logic                        byte_present;
  logic [bae_pkg::CARRY_W-1:0] carry_count;
  logic                        last_of_run;
  logic                        stream_done;

  int fail_count;
  int words_owed;
  int cycle_count = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_asks   = 0;
  int hold_seen   = 0;
  int hold_left   = 0;

  binary_arithmetic_encoder_core i_dut (.*);

  bae_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[binary_arithmetic_encoder_core] ERROR");
      $finish;
    end
  end

  // receiver: random stall, or a long hold-off when asked
  always @(posedge clk) begin
    logic nxt;
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      nxt = 1'b1;
    end else if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = 400;
      nxt = 1'b1;
    end else begin
      nxt = ($urandom_range(99) < rx_idle_pct);
    end
    out_stall <= nxt;
  end

  task automatic send_decision(input logic b, input logic [bae_pkg::PROB_W-1:0] p,
                               input logic eob);
    in_valid     <= 1'b1;
    bit_value    <= b;
    prob_one     <= p;
    end_of_block <= eob;
    do @(posedge clk); while (in_stall);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // sender pause until every owed word is out, then a margin for silent items
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_owed != 0);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [bae_pkg::PROB_W-1:0] pick_prob();
    case ($urandom_range(9))
      0:       return '0;
      1:       return bae_pkg::PROB_W'($urandom_range(8, 1));
      2:       return bae_pkg::PROB_W'($urandom_range(32767, 32760));
      default: return bae_pkg::PROB_W'($urandom_range(32767, 1));
    endcase
  endfunction

  // one coded block closed by a flush; some blocks push low towards the top
  task automatic random_block(input int n_items);
    bit                         to_top;
    logic                       b;
    logic [bae_pkg::PROB_W-1:0] p;
    to_top = ($urandom_range(3) == 0);
    for (int i = 0; i < n_items; i++) begin
      if (to_top && $urandom_range(4) != 0) begin
        b = 1'b1;
        p = bae_pkg::PROB_W'($urandom_range(200, 1));
      end else begin
        b = 1'($urandom_range(1));
        p = pick_prob();
      end
      // a stray early flush now and then
      send_decision(b, p, (i == n_items - 1) || ($urandom_range(60) == 0));
    end
  endtask

  initial begin
    int sent;
    int len;
    tx_idle_pct = 32;
    rx_idle_pct <= 78;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes of probability, renormalisation after three hard ones
    send_decision(1'b0, 15'd32767, 1'b0);
    send_decision(1'b1, 15'd32767, 1'b0);
    send_decision(1'b0, 15'd1, 1'b0);
    send_decision(1'b1, 15'd1, 1'b0);
    send_decision(1'b1, 15'd1, 1'b0);
    send_decision(1'b1, 15'd1, 1'b0);
    // zero probability is not coded
    send_decision(1'b1, 15'd0, 1'b0);
    send_decision(1'b0, 15'd16384, 1'b1);
    // flush straight from reset state
    send_decision(1'b0, 15'd0, 1'b1);
    // low driven to the top: carries and hi wrap on flush
    repeat (6) send_decision(1'b1, 15'd1, 1'b0);
    send_decision(1'b1, 15'd1, 1'b1);
    send_decision(1'b1, 15'd32767, 1'b1);
    repeat (3) send_decision(1'b0, 15'd32767, 1'b0);
    send_decision(1'b0, 15'd21845, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 32;
          rx_idle_pct <= 78;
        end
        1: begin
          tx_idle_pct = 78;
          rx_idle_pct <= 32;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
          hold_asks <= hold_asks + 1;
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = ($urandom_range(7) == 0) ? 1 : $urandom_range(40, 2);
        if (len > PHASE_ITEMS - sent) len = PHASE_ITEMS - sent;
        random_block(len);
        sent = sent + len;
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("[binary_arithmetic_encoder_core] OK");
    end else begin
      $display("[binary_arithmetic_encoder_core] ERROR");
    end
    $finish;
  end

endmodule
